### rtl/core/i2cmpt_pkg.sv
// ----------------------------------------------------------------------------
// i2cmpt_pkg
// Shared types and constants of the I2C multiplexer presence tracker.
// ----------------------------------------------------------------------------
package i2cmpt_pkg;

  localparam int unsigned ADDR_W = 7;
  localparam int unsigned SLOT_W = 7;
  localparam int unsigned CNT_W  = 4;

  localparam logic [ADDR_W-1:0] ADDR_LOW_LIMIT  = 7'd8;
  localparam logic [ADDR_W-1:0] ADDR_HIGH_LIMIT = 7'd119;
  localparam logic [CNT_W-1:0]  CNT_MAX         = 4'd15;

  // register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MUX_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MUX_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_MUX_ADDR  = 2'd2;

  localparam logic [ADDR_W-1:0] RST_FIRST_MUX_ADDR = 7'd112;
  localparam logic [ADDR_W-1:0] RST_LAST_MUX_ADDR  = 7'd119;

  // input command codes
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    KIND_QUERY        = 2'd0,
    KIND_REPORT_MUX   = 2'd1,
    KIND_REPORT_OTHER = 2'd2
  } kind_e;

  typedef struct packed {
    logic                  mux_enabled;
    logic [ADDR_W-1:0]     first_mux_addr;
    logic [ADDR_W-1:0]     last_mux_addr;
  } cfg_t;

  // one classified request between front and back
  typedef struct packed {
    kind_e                 kind;
    logic [ADDR_W-1:0]     offset;
    logic [SLOT_W-1:0]     slot;
    logic                  responding;
  } req_t;

  typedef struct packed {
    logic                  is_mux;
    logic                  change_detected;
    logic                  mux_online;
    logic [SLOT_W-1:0]     next_slot;
  } rsp_t;

endpackage

### rtl/core/i2cmpt_front.sv
// ----------------------------------------------------------------------------
// i2cmpt_front
// Classifies incoming requests: query, report of a tracked mux, other report.
// ----------------------------------------------------------------------------
module i2cmpt_front #(
  parameter int unsigned NUM_MUX = 8
) (
  input  i2cmpt_pkg::cfg_t                    cfg_i,
  input  logic                                command_i,
  input  logic [i2cmpt_pkg::ADDR_W-1:0]       dev_addr_i,
  input  logic [i2cmpt_pkg::SLOT_W-1:0]       slot_num_i,
  input  logic                                responding_i,
  output i2cmpt_pkg::req_t                    req_o
);

  logic                            win_ok;
  logic                            in_win;
  logic [i2cmpt_pkg::ADDR_W-1:0]   offset;

  assign win_ok = cfg_i.mux_enabled
               && (cfg_i.first_mux_addr >= i2cmpt_pkg::ADDR_LOW_LIMIT)
               && (cfg_i.last_mux_addr <= i2cmpt_pkg::ADDR_HIGH_LIMIT)
               && (cfg_i.first_mux_addr <= cfg_i.last_mux_addr);

  assign offset = dev_addr_i - cfg_i.first_mux_addr;

  // only the first NUM_MUX addresses of the window have table entries
  assign in_win = win_ok
               && (dev_addr_i >= cfg_i.first_mux_addr)
               && (dev_addr_i <= cfg_i.last_mux_addr)
               && ({1'b0, offset} < (i2cmpt_pkg::ADDR_W+1)'(NUM_MUX));

  always_comb begin
    req_o.offset     = offset;
    req_o.slot       = slot_num_i;
    req_o.responding = responding_i;
    if (command_i == i2cmpt_pkg::CMD_QUERY) begin
      req_o.kind = i2cmpt_pkg::KIND_QUERY;
    end else if (in_win) begin
      req_o.kind = i2cmpt_pkg::KIND_REPORT_MUX;
    end else begin
      req_o.kind = i2cmpt_pkg::KIND_REPORT_OTHER;
    end
  end

endmodule

### rtl/core/i2cmpt_queue.sv
// ----------------------------------------------------------------------------
// i2cmpt_queue
// Two-entry request queue between the classifier and the execution stage.
// ----------------------------------------------------------------------------
module i2cmpt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cmpt_pkg::req_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output i2cmpt_pkg::req_t  head_o
);

  localparam int unsigned Depth = 2;

  i2cmpt_pkg::req_t mem_q [Depth];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'(Depth));
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth))
    else $error("queue count above depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'(Depth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1 && do_pop && !do_push) |=> !valid_o)
    else $error("queue not empty after last pop");

endmodule

### rtl/core/i2cmpt_back.sv
// ----------------------------------------------------------------------------
// i2cmpt_back
// Holds the per-mux debounce state, executes reports and queries, and
// keeps the result register.
// ----------------------------------------------------------------------------
module i2cmpt_back #(
  parameter int unsigned NUM_MUX          = 8,
  parameter int unsigned SLOTS_PER_MUX    = 8,
  parameter int unsigned DETECT_THRESHOLD = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  i2cmpt_pkg::req_t  req_i,
  output logic              req_pop_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output i2cmpt_pkg::rsp_t  rsp_o
);

  localparam int unsigned IdxW = (NUM_MUX > 1) ? $clog2(NUM_MUX) : 1;
  localparam int unsigned CntW = i2cmpt_pkg::CNT_W;
  localparam int unsigned SlotW = i2cmpt_pkg::SLOT_W;

  logic              online_q [NUM_MUX];
  logic [CntW-1:0]   cnt_q    [NUM_MUX];
  logic [SlotW-1:0]  link_q   [NUM_MUX];

  logic              out_valid_q;
  i2cmpt_pkg::rsp_t  out_q, out_d;

  logic [IdxW-1:0]   idx;
  logic              cur_on, new_on;
  logic [CntW-1:0]   cur_cnt, cnt_inc, new_cnt;
  logic [SlotW-1:0]  cur_link, new_link;
  logic              chg;
  logic              upd;
  logic              found;
  logic [SlotW:0]    ans;
  logic [SlotW:0]    slot_x;
  logic [SlotW:0]    base;

  assign req_pop_o = req_valid_i && (!out_valid_q || rsp_ready_i);
  assign idx       = req_i.offset[IdxW-1:0];
  assign cur_on    = online_q[idx];
  assign cur_cnt   = cnt_q[idx];
  assign cur_link  = link_q[idx];
  assign cnt_inc   = (cur_cnt == i2cmpt_pkg::CNT_MAX) ? cur_cnt : cur_cnt + CntW'(1);
  assign upd       = req_pop_o && (req_i.kind == i2cmpt_pkg::KIND_REPORT_MUX);

  // debounce update of the addressed mux
  always_comb begin
    new_on   = cur_on;
    new_cnt  = cur_cnt;
    new_link = cur_link;
    chg      = 1'b0;
    if (req_i.responding) begin
      if (!cur_on) begin
        new_cnt = cnt_inc;
        if (cnt_inc >= CntW'(DETECT_THRESHOLD)) begin
          if (cur_link == req_i.slot) begin
            new_on = 1'b1;
            chg    = 1'b1;
          end
          new_cnt = '0;
        end
        new_link = req_i.slot;
      end else begin
        new_cnt = '0;
      end
    end else begin
      if (cur_on) begin
        // misses only count on the slot the mux was linked on
        if (cur_link == req_i.slot) begin
          new_cnt = cnt_inc;
          if (cnt_inc >= CntW'(DETECT_THRESHOLD)) begin
            new_on = 1'b0;
            chg    = 1'b1;
          end
        end
      end else begin
        new_cnt = '0;
      end
    end
  end

  // next online slot: first online mux whose slot range ends above the query
  always_comb begin
    slot_x = {1'b0, req_i.slot};
    found  = 1'b0;
    ans    = '0;
    base   = '0;
    for (int i = 0; i < NUM_MUX; i++) begin
      if (!found && online_q[i]
          && (slot_x < (SlotW+1)'((i + 1) * SLOTS_PER_MUX))) begin
        found = 1'b1;
        base  = (SlotW+1)'(i * SLOTS_PER_MUX);
        ans   = ((slot_x > base) ? slot_x : base) + (SlotW+1)'(1);
      end
    end
  end

  always_comb begin
    out_d = '0;
    case (req_i.kind)
      i2cmpt_pkg::KIND_QUERY: begin
        out_d.next_slot = ans[SlotW-1:0];
      end
      i2cmpt_pkg::KIND_REPORT_MUX: begin
        out_d.is_mux          = 1'b1;
        out_d.change_detected = chg;
        out_d.mux_online      = new_on;
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MUX; i++) begin
        online_q[i] <= 1'b0;
        cnt_q[i]    <= '0;
        link_q[i]   <= '0;
      end
    end else if (upd) begin
      online_q[idx] <= new_on;
      cnt_q[idx]    <= new_cnt;
      link_q[idx]   <= new_link;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      out_q <= out_d;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  a_change_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && chg) |=> (online_q[$past(idx)] != $past(cur_on)))
    else $error("change reported without online flip");

  a_no_change_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && !chg) |=> (online_q[$past(idx)] == $past(cur_on)))
    else $error("online flag flipped without change");

  a_query_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_pop_o && req_i.kind == i2cmpt_pkg::KIND_QUERY)
      |=> (!out_q.is_mux && !out_q.change_detected && !out_q.mux_online))
    else $error("query result carries report flags");

endmodule

### rtl/core/i2c_mux_presence_tracker_top.sv
// ----------------------------------------------------------------------------
// i2c_mux_presence_tracker_top
// Tracks online I2C multiplexers from scan reports and answers slot queries.
// ----------------------------------------------------------------------------
// Every request (a scan report or a next-slot query) yields exactly one
// result. Requests are classified on entry and held in a two-entry queue;
// the execution stage handles one request per cycle while the downstream
// side accepts results, doing the debounce update or the priority search
// over the online flags combinationally, so one request per clock is
// sustained without back-pressure. Each result is registered in an output
// register and held there while the downstream side stalls. Configuration
// writes must only occur while no request is in flight.
module i2c_mux_presence_tracker_top #(
  parameter int unsigned NUM_MUX          = 8,
  parameter int unsigned SLOTS_PER_MUX    = 8,
  parameter int unsigned DETECT_THRESHOLD = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [i2cmpt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [i2cmpt_pkg::ADDR_W-1:0]         cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [15:0]                           s_axis_tdata,  // dev_addr, slot_num, responding
  input  logic                                  s_axis_tuser,  // command
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [15:0]                           m_axis_tdata   // is_mux, change_detected,
                                                               // mux_online, next_slot
);

  i2cmpt_pkg::cfg_t cfg_q;
  i2cmpt_pkg::req_t req_in;
  i2cmpt_pkg::req_t req_head;
  i2cmpt_pkg::rsp_t rsp;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mux_enabled    <= 1'b1;
      cfg_q.first_mux_addr <= i2cmpt_pkg::RST_FIRST_MUX_ADDR;
      cfg_q.last_mux_addr  <= i2cmpt_pkg::RST_LAST_MUX_ADDR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cmpt_pkg::CFG_MUX_ENABLED:    cfg_q.mux_enabled    <= cfg_wdata_i[0];
        i2cmpt_pkg::CFG_FIRST_MUX_ADDR: cfg_q.first_mux_addr <= cfg_wdata_i;
        i2cmpt_pkg::CFG_LAST_MUX_ADDR:  cfg_q.last_mux_addr  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  i2cmpt_front #(
    .NUM_MUX (NUM_MUX)
  ) u_front (
    .cfg_i        (cfg_q),
    .command_i    (s_axis_tuser),
    .dev_addr_i   (s_axis_tdata[6:0]),
    .slot_num_i   (s_axis_tdata[13:7]),
    .responding_i (s_axis_tdata[14]),
    .req_o        (req_in)
  );

  assign s_axis_tready = !q_full;

  i2cmpt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (req_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (req_head)
  );

  i2cmpt_back #(
    .NUM_MUX          (NUM_MUX),
    .SLOTS_PER_MUX    (SLOTS_PER_MUX),
    .DETECT_THRESHOLD (DETECT_THRESHOLD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_i       (req_head),
    .req_pop_o   (q_pop),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_o       (rsp)
  );

  assign m_axis_tdata = {6'd0, rsp.next_slot, rsp.mux_online, rsp.change_detected,
                         rsp.is_mux};

endmodule
